// ----- hw/rtl/pab64_pkg.sv -----
// ---------------------------------------------------------------------------
// pab64_pkg
// Shared constants, types and character helpers of the PEM armor base64
// extractor: armor prefixes, the base64 character class and the line job.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pab64_pkg;

    // Line buffer size range and default
    localparam int LINE_KEEP_MAX_DEF = 64;
    localparam int LINE_KEEP_LIMIT   = 64;

    // Count field of a line job covers the largest legal buffer
    localparam int JOB_CNT_W = $clog2(LINE_KEEP_LIMIT + 1);

    // Armor prefix lengths and column saturation point
    localparam logic [3:0] BEGIN_LEN  = 4'd11;
    localparam logic [3:0] END_LEN    = 4'd9;
    localparam logic [3:0] COLUMN_SAT = 4'd11;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // One completed body line waiting to be drained
    typedef struct packed {
        logic                 bank;
        logic                 overflow;
        logic [JOB_CNT_W-1:0] count;
    } job_t;

    // Drain engine states
    typedef enum logic {
        BK_IDLE,
        BK_SHOW
    } back_state_t;

    // Expected character of "-----BEGIN " at a column
    function automatic logic [7:0] begin_char(input logic [3:0] col);
        logic [7:0] ch;
        unique case (col) inside
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = CH_DASH;
            4'd5:    ch = "B";
            4'd6:    ch = "E";
            4'd7:    ch = "G";
            4'd8:    ch = "I";
            4'd9:    ch = "N";
            4'd10:   ch = CH_SPACE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected character of "-----END " at a column
    function automatic logic [7:0] end_char(input logic [3:0] col);
        logic [7:0] ch;
        unique case (col) inside
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = CH_DASH;
            4'd5:    ch = "E";
            4'd6:    ch = "N";
            4'd7:    ch = "D";
            4'd8:    ch = CH_SPACE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Base64 character class: letters, digits, plus, slash, equal
    function automatic logic is_b64(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               ((c >= "0") && (c <= "9")) || (c == CH_PLUS) ||
               (c == CH_SLASH) || (c == CH_EQUAL);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pab64_ram.sv -----
// ---------------------------------------------------------------------------
// pab64_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pab64_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pab64_job_fifo.sv -----
// ---------------------------------------------------------------------------
// pab64_job_fifo
// Two-entry queue of completed body lines between the byte front end and
// the drain engine; one entry for each half of the line buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pab64_job_fifo
    import pab64_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output logic      empty,
    output logic      full
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign empty    = (fill_reg == 2'd0);
    assign full     = (fill_reg == 2'd2);
    assign head_job = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pab64_front.sv -----
// ---------------------------------------------------------------------------
// pab64_front
// Byte front end: tracks the armor prefixes and skipping mode, stores the
// kept base64 characters of the current line in one half of the line
// buffer, and queues a line job at each newline of a body line that kept characters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pab64_front
    import pab64_pkg::*;
#(
    parameter int LINE_KEEP_MAX = LINE_KEEP_MAX_DEF,
    parameter int ADDR_W        = $clog2(2 * LINE_KEEP_MAX)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        text_byte,
    input  wire logic              new_object,
    output logic                   push,
    output job_t                   push_job,
    output logic                   wr_en,
    output logic      [ADDR_W-1:0] wr_addr,
    output logic      [7:0]        wr_data
);

    localparam int CNT_W = $clog2(LINE_KEEP_MAX + 1);
    localparam int IDX_W = $clog2(LINE_KEEP_MAX);

    logic             skipping_reg, skipping_next;
    logic [3:0]       column_reg, column_next;
    logic             begin_ok_reg, begin_ok_next;
    logic             end_ok_reg, end_ok_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;

    logic             skip_eff;
    logic [3:0]       col_eff;
    logic             begin_eff;
    logic             end_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic             ovf_eff;
    logic             is_begin;
    logic             is_end;
    logic [IDX_W-1:0] wr_idx;

    assign wr_data = text_byte;
    assign wr_idx  = cnt_eff[IDX_W-1:0];

    // Classify the accepted byte and update the line state
    always_comb
    begin
        skipping_next = skipping_reg;
        column_next   = column_reg;
        begin_ok_next = begin_ok_reg;
        end_ok_next   = end_ok_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        bank_next     = bank_reg;
        push          = 1'b0;
        wr_en         = 1'b0;

        // New object drops the open line and returns to skipping
        skip_eff  = new_object ? 1'b1 : skipping_reg;
        col_eff   = new_object ? 4'd0 : column_reg;
        begin_eff = new_object ? 1'b1 : begin_ok_reg;
        end_eff   = new_object ? 1'b1 : end_ok_reg;
        cnt_eff   = new_object ? '0 : count_reg;
        ovf_eff   = new_object ? 1'b0 : ovf_reg;

        is_begin = begin_eff && (col_eff >= BEGIN_LEN);
        is_end   = end_eff && (col_eff >= END_LEN);

        push_job.bank     = bank_reg;
        push_job.overflow = ovf_eff;
        push_job.count    = JOB_CNT_W'(cnt_eff);

        wr_addr = bank_reg ? (ADDR_W'(LINE_KEEP_MAX) + ADDR_W'(wr_idx)) : ADDR_W'(wr_idx);

        if (accept)
        begin
            if (text_byte == CH_NEWLINE)
            begin
                skipping_next = skip_eff;
                if (is_begin)
                begin
                    skipping_next = 1'b0;
                end
                else if (is_end)
                begin
                    skipping_next = 1'b1;
                end
                else if (!skip_eff && (cnt_eff != '0))
                begin
                    // Hand the finished line over and switch buffer halves
                    push      = 1'b1;
                    bank_next = ~bank_reg;
                end
                column_next   = 4'd0;
                begin_ok_next = 1'b1;
                end_ok_next   = 1'b1;
                count_next    = '0;
                ovf_next      = 1'b0;
            end
            else
            begin
                skipping_next = skip_eff;
                begin_ok_next = begin_eff;
                end_ok_next   = end_eff;
                count_next    = cnt_eff;
                ovf_next      = ovf_eff;
                column_next   = col_eff;
                if ((col_eff < BEGIN_LEN) && (text_byte != begin_char(col_eff)))
                begin
                    begin_ok_next = 1'b0;
                end
                if ((col_eff < END_LEN) && (text_byte != end_char(col_eff)))
                begin
                    end_ok_next = 1'b0;
                end
                if (col_eff < COLUMN_SAT)
                begin
                    column_next = col_eff + 4'd1;
                end
                // Keep base64 characters, drop and flag the excess
                if (is_b64(text_byte))
                begin
                    if (cnt_eff < CNT_W'(LINE_KEEP_MAX))
                    begin
                        wr_en      = 1'b1;
                        count_next = cnt_eff + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
        end
    end

    // Hold line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skipping_reg <= 1'b1;
            column_reg   <= 4'd0;
            begin_ok_reg <= 1'b1;
            end_ok_reg   <= 1'b1;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            bank_reg     <= 1'b0;
        end
        else
        begin
            skipping_reg <= skipping_next;
            column_reg   <= column_next;
            begin_ok_reg <= begin_ok_next;
            end_ok_reg   <= end_ok_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            bank_reg     <= bank_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pab64_back.sv -----
// ---------------------------------------------------------------------------
// pab64_back
// Drain engine: takes queued line jobs and reads their characters out of
// the line buffer one per cycle while out_ready is high, marking the last one of each line.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pab64_back
    import pab64_pkg::*;
#(
    parameter int LINE_KEEP_MAX = LINE_KEEP_MAX_DEF,
    parameter int ADDR_W        = $clog2(2 * LINE_KEEP_MAX)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_empty,
    input  wire job_t              head_job,
    output logic                   pop,
    output logic                   rd_en,
    output logic      [ADDR_W-1:0] rd_addr,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_last,
    output logic                   out_ovf
);

    localparam int IDX_W = $clog2(LINE_KEEP_MAX);

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             last_char;
    logic             rd_bank;
    logic [IDX_W-1:0] rd_idx;

    assign last_char = ((JOB_CNT_W'(idx_reg) + 1'b1) == job_reg.count);
    assign out_valid = (state_reg == BK_SHOW);
    assign out_last  = last_char;
    assign out_ovf   = job_reg.overflow;
    assign rd_addr   = rd_bank ? (ADDR_W'(LINE_KEEP_MAX) + ADDR_W'(rd_idx))
                               : ADDR_W'(rd_idx);

    // Sequence reads: prefetch the next character as the current one leaves
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_bank    = job_reg.bank;
        rd_idx     = idx_reg + 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    rd_bank    = head_job.bank;
                    rd_idx     = '0;
                    job_next   = head_job;
                    idx_next   = '0;
                    state_next = BK_SHOW;
                end
            end
            BK_SHOW:
            begin
                if (out_ready)
                begin
                    if (!last_char)
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                    else if (!job_empty)
                    begin
                        pop      = 1'b1;
                        rd_en    = 1'b1;
                        rd_bank  = head_job.bank;
                        rd_idx   = '0;
                        job_next = head_job;
                        idx_next = '0;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Hold drain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold current job and character index
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pem_armor_base64_extractor.sv -----
// ---------------------------------------------------------------------------
// pem_armor_base64_extractor
// Strips PEM armor lines and line breaks from a byte stream and delivers
// the base64 body characters of each body line, last one marked.
// ---------------------------------------------------------------------------
//  Channel | Dir | tdata           | tlast     | tuser
//  s_*     | in  | [7:0] text_byte | -         | new_object
//  m_*     | out | [7:0] char_out  | line_end  | line_overflowed
//
//  Each byte is taken when s_tvalid and s_tready are both high. A body line
//  drains from the line buffer at one character per cycle while m_tready is high.
//  The line buffer has two halves; s_tready drops while both hold lines not
//  yet drained. m_tvalid holds with stable data until m_tready is seen.
//  Reset returns to skipping mode with an empty line and an empty queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pem_armor_base64_extractor
    import pab64_pkg::*;
#(
    parameter int LINE_KEEP_MAX = LINE_KEEP_MAX_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tuser,   // [0] new_object
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] char_out
    output logic            m_tlast,   // line_end
    output logic            m_tuser    // [0] line_overflowed
);

    localparam int DEPTH  = 2 * LINE_KEEP_MAX;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              accept;
    logic              push;
    job_t              push_job;
    logic              pop;
    job_t              head_job;
    logic              job_empty;
    logic              job_full;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Hold input while both buffer halves carry lines: queued or draining
    assign s_tready = !job_full && !(m_tvalid && !job_empty);
    assign accept   = s_tvalid && s_tready;

    // Classify bytes and fill the line buffer
    pab64_front #(
        .LINE_KEEP_MAX (LINE_KEEP_MAX),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (s_tdata),
        .new_object (s_tuser),
        .push       (push),
        .push_job   (push_job),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // Queue completed lines
    pab64_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (job_empty),
        .full     (job_full)
    );

    // Line buffer, two halves
    pab64_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (m_tdata)
    );

    // Drain lines to the output
    pab64_back #(
        .LINE_KEEP_MAX (LINE_KEEP_MAX),
        .ADDR_W        (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .head_job  (head_job),
        .pop       (pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser)
    );

endmodule

`default_nettype wire
